// File: hw/rtl/nsc_pkg.sv
package nsc_pkg;

    localparam int NUM_SEEDS_DEF    = 16;
    localparam int IMAGE_WIDTH_DEF  = 1024;
    localparam int IMAGE_HEIGHT_DEF = 1024;

    localparam int COORD_W = 10;
    localparam int SLOT_W  = 4;
    localparam int INDEX_W = 4;
    localparam int SQ_W    = 2 * COORD_W;
    localparam int DIST_W  = SQ_W + 1;
    localparam int LIMIT_W = 13;
    localparam int COUNT_W = 7;

    typedef enum logic {
        FUNC_LOAD     = 1'b0,
        FUNC_CLASSIFY = 1'b1
    } t_func;

    typedef struct packed {
        t_func              func;
        logic [SLOT_W-1:0]  seed_slot;
        logic [COORD_W-1:0] seed_x;
        logic [COORD_W-1:0] seed_y;
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
    } t_in_item;

    typedef struct packed {
        logic [INDEX_W-1:0] nearest_index;
        logic [DIST_W-1:0]  nearest_dist_sq;
    } t_out_item;

endpackage

// File: hw/rtl/nearest_seed_classifier.sv
// nearest seed classifier
// input channel: i_valid / o_stall with payload i_data. a load beat (func load)
// writes one seed into the table, a classify beat gives a pixel coordinate.
// output channel: o_valid / i_stall with payload o_data, one beat per classify
// beat whose pixel lies inside the image: the nearest seed index (lowest index
// on ties) and its squared distance. loads, out-of-range slots and pixels
// outside the image give no output beat.
// the steps from input beat to output beat are abs difference, square, sum,
// then one compare level of the minimum tree per stage. throughput: one beat
// per cycle while the output is not stalled, loads and classifies in any mix;
// the table is read as the classify beat is taken, so a load takes effect for
// every later classify beat.
// reset: synchronous, active low; clears the seed table to (0, 0) and empties
// the pipeline.
// a stall on the output holds the whole pipeline while a result waits, and
// o_stall is raised toward the input in the same cycle.
module nearest_seed_classifier
    import nsc_pkg::*;
#(
    parameter int NUM_SEEDS    = NUM_SEEDS_DEF,
    parameter int IMAGE_WIDTH  = IMAGE_WIDTH_DEF,
    parameter int IMAGE_HEIGHT = IMAGE_HEIGHT_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_data,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_data
);

    localparam int IW     = $clog2(NUM_SEEDS);
    localparam int PAD    = 1 << IW;
    localparam int LEVELS = IW;

    logic [COORD_W-1:0] r_seed_x [NUM_SEEDS];
    logic [COORD_W-1:0] r_seed_y [NUM_SEEDS];

    logic               r_s1_valid;
    logic [COORD_W-1:0] r_dx [NUM_SEEDS];
    logic [COORD_W-1:0] r_dy [NUM_SEEDS];

    logic               r_s2_valid;
    logic [SQ_W-1:0]    r_sqx [NUM_SEEDS];
    logic [SQ_W-1:0]    r_sqy [NUM_SEEDS];

    logic               r_lvl_v [LEVELS+1];
    logic [DIST_W-1:0]  r_lvl_d [LEVELS+1][PAD];
    logic [IW-1:0]      r_lvl_i [LEVELS+1][PAD];

    logic               en;
    logic               accept;
    logic               seed_wr;
    logic               pix_ok;
    logic               n_s1_valid;
    logic [IW+3:0]      idx_ext;

    assign en      = !(r_lvl_v[LEVELS] && i_stall);
    assign o_stall = !en;
    assign accept  = i_valid && en;

    assign seed_wr = accept && (i_data.func == FUNC_LOAD)
                     && ({3'b0, i_data.seed_slot} < COUNT_W'(NUM_SEEDS));
    assign pix_ok  = ({3'b0, i_data.pixel_x} < LIMIT_W'(IMAGE_WIDTH))
                     && ({3'b0, i_data.pixel_y} < LIMIT_W'(IMAGE_HEIGHT));
    assign n_s1_valid = accept && (i_data.func == FUNC_CLASSIFY) && pix_ok;

    // seed table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int e = 0; e < NUM_SEEDS; e++) begin
                r_seed_x[e] <= '0;
                r_seed_y[e] <= '0;
            end
        end else if (seed_wr) begin
            for (int e = 0; e < NUM_SEEDS; e++) begin
                if ({3'b0, i_data.seed_slot} == COUNT_W'(e)) begin
                    r_seed_x[e] <= i_data.seed_x;
                    r_seed_y[e] <= i_data.seed_y;
                end
            end
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            for (int k = 0; k <= LEVELS; k++) begin
                r_lvl_v[k] <= 1'b0;
            end
        end else if (en) begin
            r_s1_valid <= n_s1_valid;
            r_s2_valid <= r_s1_valid;
            r_lvl_v[0] <= r_s2_valid;
            for (int k = 1; k <= LEVELS; k++) begin
                r_lvl_v[k] <= r_lvl_v[k-1];
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int e = 0; e < NUM_SEEDS; e++) begin
                r_dx[e] <= (i_data.pixel_x > r_seed_x[e]) ? i_data.pixel_x - r_seed_x[e]
                                                          : r_seed_x[e] - i_data.pixel_x;
                r_dy[e] <= (i_data.pixel_y > r_seed_y[e]) ? i_data.pixel_y - r_seed_y[e]
                                                          : r_seed_y[e] - i_data.pixel_y;
                r_sqx[e] <= SQ_W'(r_dx[e]) * SQ_W'(r_dx[e]);
                r_sqy[e] <= SQ_W'(r_dy[e]) * SQ_W'(r_dy[e]);
            end
            for (int j = 0; j < PAD; j++) begin
                r_lvl_i[0][j] <= IW'(j);
                if (j < NUM_SEEDS) begin
                    r_lvl_d[0][j] <= {1'b0, r_sqx[j]} + {1'b0, r_sqy[j]};
                end else begin
                    // padding entries never win
                    r_lvl_d[0][j] <= '1;
                end
            end
            // minimum tree, lower index kept unless right is strictly closer
            for (int k = 1; k <= LEVELS; k++) begin
                for (int j = 0; j < (PAD >> k); j++) begin
                    if (r_lvl_d[k-1][2*j] > r_lvl_d[k-1][2*j+1]) begin
                        r_lvl_d[k][j] <= r_lvl_d[k-1][2*j+1];
                        r_lvl_i[k][j] <= r_lvl_i[k-1][2*j+1];
                    end else begin
                        r_lvl_d[k][j] <= r_lvl_d[k-1][2*j];
                        r_lvl_i[k][j] <= r_lvl_i[k-1][2*j];
                    end
                end
            end
        end
    end

    assign idx_ext                = {4'b0, r_lvl_i[LEVELS][0]};
    assign o_valid                = r_lvl_v[LEVELS];
    assign o_data.nearest_index   = idx_ext[INDEX_W-1:0];
    assign o_data.nearest_dist_sq = r_lvl_d[LEVELS][0];

endmodule
